[hw/rtl/tsg_pkg.sv]
// Shared types and constants for the touch sweep gesture detector.
// Used by the channel interfaces, the sweep logic and the top level.
// No dependencies.
package tsg_pkg;

  // Widths of the beat fields and the configuration port.
  localparam int FUNC_W     = 3;
  localparam int COORD_W    = 12;
  localparam int LEVEL_W    = 7;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  // Wide enough for a coordinate plus the full 560 run, either sign.
  localparam int CALC_W     = 14;

  // Event kinds.
  localparam logic [FUNC_W-1:0] FUNC_OTHER = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SLOT  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TRKID = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POS_X = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_POS_Y = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIB_STR    = 1'd1;

  // Mode bits.
  localparam int MODE_RIGHT_BIT = 0;
  localparam int MODE_LEFT_BIT  = 1;

  // Geometry of the sweep.
  localparam logic signed [CALC_W-1:0] BAND_Y_LIMIT    = 14'sd1740;
  localparam logic signed [CALC_W-1:0] RIGHT_START_MAX = 14'sd810;
  localparam logic signed [CALC_W-1:0] ZONE_ONE        = 14'sd180;
  localparam logic signed [CALC_W-1:0] ZONE_TWO        = 14'sd200;
  localparam logic signed [CALC_W-1:0] FINAL_RUN       = 14'sd180;

  // A tracking id of -1 releases the touch.
  localparam logic signed [COORD_W-1:0] TRKID_RELEASE = -12'sd1;

  // Strength limits and reset values.
  localparam logic [LEVEL_W-1:0] STRENGTH_MAX     = 7'd90;
  localparam logic [LEVEL_W-1:0] STRENGTH_DEFAULT = 7'd20;
  localparam logic [MODE_W-1:0]  MODE_DEFAULT     = 2'd2;

  // Gesture tracking state carried from one event to the next.
  typedef struct packed {
    logic signed [COORD_W-1:0] latched_x;
    logic signed [COORD_W-1:0] latched_y;
    logic                      x_seen;
    logic                      y_seen;
    logic signed [COORD_W-1:0] start_x;
    logic                      first_passed;
    logic                      second_passed;
    logic                      armed;
  } gest_state_t;

  localparam gest_state_t GEST_RESET = '{
    latched_x:     '0,
    latched_y:     '0,
    x_seen:        1'b0,
    y_seen:        1'b0,
    start_x:       '0,
    first_passed:  1'b0,
    second_passed: 1'b0,
    armed:         1'b1
  };

endpackage

[hw/rtl/tsg_if.sv]
// Valid/ready channel interfaces for touch events and trigger results.
// Depends on tsg_pkg for the field widths.
interface tsg_in_if;
  logic                                        valid;
  logic                                        ready;
  logic [tsg_pkg::FUNC_W-1:0]                  func;
  logic signed [tsg_pkg::COORD_W-1:0]          value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface tsg_out_if;
  logic                              valid;
  logic                              ready;
  logic                              power_trigger;
  logic [tsg_pkg::LEVEL_W-1:0]       vibrate_level;

  modport source (output valid, output power_trigger, output vibrate_level, input ready);
  modport sink   (input valid, input power_trigger, input vibrate_level, output ready);
endinterface

[hw/rtl/tsg_sweep.sv]
// Next-state logic of the gesture tracker for one touch event.
// Depends on tsg_pkg for the state struct and sweep geometry.
module tsg_sweep (
  input  logic [tsg_pkg::FUNC_W-1:0]         func,
  input  logic signed [tsg_pkg::COORD_W-1:0] value,
  input  logic [tsg_pkg::MODE_W-1:0]         mode,
  input  tsg_pkg::gest_state_t               state,
  output tsg_pkg::gest_state_t               state_next,
  output logic                               fire
);

  tsg_pkg::gest_state_t        lat;
  logic signed [tsg_pkg::CALC_W-1:0] x;
  logic signed [tsg_pkg::CALC_W-1:0] y;
  logic signed [tsg_pkg::CALC_W-1:0] start;
  logic signed [tsg_pkg::CALC_W-1:0] r_b1, r_b2, r_end;
  logic signed [tsg_pkg::CALC_W-1:0] l_b1, l_b2, l_end;
  logic low;
  logic clear;
  logic go_right, go_left;
  logic r_pass1, r_pass2, r_fire;
  logic l_pass1, l_pass2, l_fire;

  // Release or slot change clears the gesture.
  assign clear = (func == tsg_pkg::FUNC_SLOT) ||
                 ((func == tsg_pkg::FUNC_TRKID) && (value == tsg_pkg::TRKID_RELEASE));

  // Latch the coordinates carried by this event.
  always_comb begin
    lat = state;
    if (func == tsg_pkg::FUNC_POS_X) begin
      lat.latched_x = value;
      lat.x_seen    = 1'b1;
    end
    if (func == tsg_pkg::FUNC_POS_Y) begin
      lat.latched_y = value;
      lat.y_seen    = 1'b1;
    end
  end

  // Sign-extended working values; a zero start means the touch has no start yet.
  assign x     = tsg_pkg::CALC_W'(lat.latched_x);
  assign y     = tsg_pkg::CALC_W'(lat.latched_y);
  assign start = (lat.start_x == '0) ? x : tsg_pkg::CALC_W'(lat.start_x);
  assign low   = y > tsg_pkg::BAND_Y_LIMIT;

  // Direction choice: rightward wins for starts below RIGHT_START_MAX when its mode bit is set.
  assign go_right = (start < tsg_pkg::RIGHT_START_MAX) && mode[tsg_pkg::MODE_RIGHT_BIT];
  assign go_left  = !go_right && (start >= tsg_pkg::ZONE_ONE) &&
                    mode[tsg_pkg::MODE_LEFT_BIT];

  // Barrier edges for the rightward sweep.
  assign r_b1  = start + tsg_pkg::ZONE_ONE;
  assign r_b2  = r_b1 + tsg_pkg::ZONE_TWO;
  assign r_end = r_b2 + tsg_pkg::FINAL_RUN;
  assign r_pass1 = lat.first_passed || ((x > start) && (x < r_b1) && low);
  assign r_pass2 = r_pass1 && (lat.second_passed || ((x > r_b1) && (x < r_b2) && low));
  assign r_fire  = r_pass2 && (x > r_b2) && low && (x > r_end) && lat.armed;

  // Barrier edges for the leftward sweep.
  assign l_b1  = start - tsg_pkg::ZONE_ONE;
  assign l_b2  = l_b1 - tsg_pkg::ZONE_TWO;
  assign l_end = l_b2 - tsg_pkg::FINAL_RUN;
  assign l_pass1 = lat.first_passed || ((x < start) && (x > l_b1) && low);
  assign l_pass2 = l_pass1 && (lat.second_passed || ((x < l_b1) && (x > l_b2) && low));
  assign l_fire  = l_pass2 && (x < l_b2) && low && (x < l_end) && lat.armed;

  // Assemble the next state and the trigger.
  always_comb begin
    state_next = lat;
    fire       = 1'b0;
    if (clear) begin
      state_next               = state;
      state_next.armed         = 1'b1;
      state_next.first_passed  = 1'b0;
      state_next.second_passed = 1'b0;
      state_next.start_x       = '0;
    end else if (lat.x_seen && lat.y_seen) begin
      state_next.x_seen  = 1'b0;
      state_next.y_seen  = 1'b0;
      state_next.start_x = start[tsg_pkg::COORD_W-1:0];
      if (go_right) begin
        if (r_pass1) state_next.first_passed = 1'b1;
        if (r_pass2) state_next.second_passed = 1'b1;
        if (r_fire) begin
          state_next.armed = 1'b0;
          fire             = 1'b1;
        end
      end else if (go_left) begin
        if (l_pass1) state_next.first_passed = 1'b1;
        if (l_pass2) state_next.second_passed = 1'b1;
        if (l_fire) begin
          state_next.armed = 1'b0;
          fire             = 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/touch_sweep_gesture_detector.sv]
// Top level of the touch sweep gesture detector.
// Depends on tsg_pkg, tsg_if.sv and tsg_sweep.
//
// Touch events enter an input register and are processed one per clock as they
// move into the result register, so the block sustains one event per cycle while
// the sink takes each result beat, stalling when it does not. Every event gives
// exactly one result beat: power_trigger is high on the beat of the event that
// completes a sweep along the bottom band, and vibrate_level then carries the
// configured strength (zero otherwise). The two-entry register chain lets a new
// event be taken while a finished result waits for the sink. Configuration
// writes take effect on the next clock and should be made while the block is idle.
module touch_sweep_gesture_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  tsg_in_if.sink                              in_ch,
  tsg_out_if.source                           out_ch
);

  // Configuration registers.
  logic [tsg_pkg::MODE_W-1:0]  sweep_mode;
  logic [tsg_pkg::LEVEL_W-1:0] vibrate_strength;

  // Input register.
  logic                                s1_valid;
  logic [tsg_pkg::FUNC_W-1:0]          s1_func;
  logic signed [tsg_pkg::COORD_W-1:0]  s1_value;
  logic                                s1_adv;

  // Result register.
  logic                                o_valid;
  logic                                o_trigger;
  logic [tsg_pkg::LEVEL_W-1:0]         o_level;

  // Gesture state.
  tsg_pkg::gest_state_t gest;
  tsg_pkg::gest_state_t gest_next;
  logic                 fire;

  assign s1_adv       = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || s1_adv;

  assign out_ch.valid         = o_valid;
  assign out_ch.power_trigger = o_trigger;
  assign out_ch.vibrate_level = o_level;

  tsg_sweep u_sweep (
    .func       (s1_func),
    .value      (s1_value),
    .mode       (sweep_mode),
    .state      (gest),
    .state_next (gest_next),
    .fire       (fire)
  );

  // Configuration writes; an out-of-range strength falls back to the default.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_mode       <= tsg_pkg::MODE_DEFAULT;
      vibrate_strength <= tsg_pkg::STRENGTH_DEFAULT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tsg_pkg::CFG_SWEEP_MODE: sweep_mode <= cfg_wdata[tsg_pkg::MODE_W-1:0];
        tsg_pkg::CFG_VIB_STR: begin
          vibrate_strength <= (cfg_wdata > tsg_pkg::STRENGTH_MAX) ?
                              tsg_pkg::STRENGTH_DEFAULT : cfg_wdata;
        end
        default: ;
      endcase
    end
  end

  // Input register captures each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_func  <= in_ch.func;
      s1_value <= in_ch.value;
    end
  end

  // Gesture state advances as each event moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gest <= tsg_pkg::GEST_RESET;
    end else if (s1_adv) begin
      gest <= gest_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
    if (s1_adv) begin
      o_trigger <= fire;
      o_level   <= fire ? vibrate_strength : '0;
    end
  end

  // A result without a trigger never carries a strength.
  a_level_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_trigger) |-> (o_level == '0))
    else $error("vibrate_level set without power_trigger");

  // A trigger disarms the gesture until it is cleared.
  a_disarm: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && fire) |=> !gest.armed)
    else $error("trigger fired but gesture still armed");

  // The second barrier is never marked without the first.
  a_barrier_order: assert property (@(posedge clk) disable iff (rst)
    gest.second_passed |-> gest.first_passed)
    else $error("second barrier passed without the first");

  // With the result register empty the input side is never stalled.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !o_valid |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule
